/* hw/rtl/fis_pkg.sv */
// fis_pkg: shared types, constants and the sine-table entry function for the
// fractal interface synthesizer. No dependencies.
`timescale 1ns / 1ps
package fis_pkg;

	localparam logic [63:0] PI_Q30   = 64'd3373259426;
	localparam logic [63:0] ONE_Q30  = 64'd1073741824;
	localparam logic [34:0] LCG_MUL  = 35'h5DEECE66D;
	localparam logic [47:0] LCG_ADD  = 48'hB;
	localparam logic [15:0] SEED_LOW = 16'h330E;

	localparam logic [2:0] REG_SEED       = 3'd0;
	localparam logic [2:0] REG_NUM_TERMS  = 3'd1;
	localparam logic [2:0] REG_BASE_STEP  = 3'd2;
	localparam logic [2:0] REG_FREQ_RATIO = 3'd3;
	localparam logic [2:0] REG_TERM_DECAY = 3'd4;
	localparam logic [2:0] REG_AMP_SCALE  = 3'd5;
	localparam logic [2:0] REG_INV_DZ     = 3'd6;

	// one term as held in a cell: phase Q0.32, low step word, weight Q1.24
	typedef struct packed {
		logic [31:0] phase;
		logic [31:0] step;
		logic [24:0] weight;
	} term_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REBUILD,
		ST_RUN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FIN1,
		ST_FIN2
	} state_t;

	// Q15 sine of x (Q30 radians) by a nested Taylor series, capped at 32767
	function automatic logic [14:0] sine_entry(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] e;
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		e  = (((x * t) >> 30) + 64'd16384) >> 15;
		return (e > 64'd32767) ? 15'h7FFF : e[14:0];
	endfunction

endpackage

/* hw/rtl/fractal_interface_synth.sv */
// Fractal interface synthesizer: depth sample plus Weierstrass-Mandelbrot profile.
// An accepted sample goes through the rebuild (first column or unprimed only), run, drain
// and finish states; a new sample is taken only in idle, once the last result is loaded.
// The term ring paces this, rotating once per column past one shared sine/multiply unit.
// Reset: config registers return to defaults, generator unprimed; the first column rebuilds.
// Depends on fis_pkg, fis_cell, fis_term_gen, fis_sine_rom.
`timescale 1ns / 1ps
module fractal_interface_synth #(
	parameter int MAX_TERMS        = 32,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] interface_depth,
	input  logic        first_column,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] depth_index,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import fis_pkg::*;

	localparam int CW    = $clog2(MAX_TERMS + 1);
	localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int SUM_W = 41 + $clog2(MAX_TERMS);
	localparam int FQ_W  = SUM_W - 15 + 32;

	// configuration registers
	logic [31:0] seed_q, base_step_q, freq_ratio_q, amp_scale_q, inv_dz_q;
	logic [23:0] term_decay_q;
	logic [5:0]  num_terms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= '0;
			num_terms_q  <= 6'd8;
			base_step_q  <= '0;
			freq_ratio_q <= 32'd33554432;
			term_decay_q <= 24'd8388608;
			amp_scale_q  <= 32'd65536;
			inv_dz_q     <= 32'd16777216;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEED:       seed_q       <= cfg_data;
				REG_NUM_TERMS:  num_terms_q  <= cfg_data[5:0];
				REG_BASE_STEP:  base_step_q  <= cfg_data;
				REG_FREQ_RATIO: freq_ratio_q <= cfg_data;
				REG_TERM_DECAY: term_decay_q <= cfg_data[23:0];
				REG_AMP_SCALE:  amp_scale_q  <= cfg_data;
				REG_INV_DZ:     inv_dz_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	state_t      state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic        primed_q;
	logic        gen_load, gen_adv, shift;
	logic        accept;
	logic        out_load;
	logic [31:0] depth_q;

	assign accept = in_valid && in_ready;

	// term ring: cell 0 is the head, the tail takes the feedback or generator term
	term_t cell_q [MAX_TERMS];
	term_t gen_term, head, feed;

	assign head = cell_q[0];

	for (genvar k = 0; k < MAX_TERMS; k++) begin : g_ring
		if (k == MAX_TERMS - 1) begin : g_tail
			fis_cell u_cell (.clk(clk), .shift(shift), .d(feed), .q(cell_q[k]));
		end else begin : g_mid
			fis_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[k+1]), .q(cell_q[k]));
		end
	end

	fis_term_gen u_gen (
		.clk       (clk),
		.load      (gen_load),
		.adv       (gen_adv),
		.seed      (seed_q),
		.base_step (base_step_q),
		.freq_ratio(freq_ratio_q),
		.term_decay(term_decay_q),
		.term      (gen_term)
	);

	always_comb begin
		feed = gen_term;
		if (state_q == ST_RUN) begin
			feed = '{phase: head.phase + head.step, step: head.step, weight: head.weight};
		end
	end

	// sine lookup on the head phase
	logic [30+AW-1:0] idx_prod;
	logic [AW-1:0]    idx, rom_addr;
	logic [14:0]      rom_data;

	assign idx_prod = (30+AW)'(head.phase[29:0]) * (30+AW)'(SINE_TABLE_DEPTH);
	assign idx      = idx_prod[30+AW-1:30];
	assign rom_addr = head.phase[30] ? AW'(SINE_TABLE_DEPTH) - idx : idx;

	fis_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
		.clk (clk),
		.addr(rom_addr),
		.data(rom_data)
	);

	// active-term test: num_terms clipped to MAX_TERMS
	logic [7:0] n_eff;
	logic       act;
	assign n_eff = (8'(num_terms_q) > 8'(MAX_TERMS)) ? 8'(MAX_TERMS) : 8'(num_terms_q);
	assign act   = (state_q == ST_RUN) && (8'(cnt_q) < n_eff);

	// multiply-accumulate pipeline
	logic              act_s1, neg_s1, act_s2, neg_s2;
	logic [24:0]       w_s1;
	logic [39:0]       mag_s2;
	logic signed [SUM_W-1:0] sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= act;
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= head.phase[31];
		w_s1   <= head.weight;
		neg_s2 <= neg_s1;
		mag_s2 <= 40'(w_s1) * 40'(rom_data);
		if (accept) begin
			sum_q <= '0;
			depth_q <= interface_depth;
		end else if (act_s2) begin
			sum_q <= neg_s2 ? sum_q - SUM_W'(mag_s2) : sum_q + SUM_W'(mag_s2);
		end
	end

	// combine: magnitudes scaled, signs restored, rounded and saturated
	logic             fneg, dneg;
	logic [SUM_W-1:0] fmag;
	logic [31:0]      dmag;
	logic [FQ_W-1:0]  fq_full;
	logic [63:0]      dq_full;
	logic [FQ_W-9:0]  fq_s1;
	logic [59:0]      dq_s1;
	logic             fneg_s1, dneg_s1;

	assign fneg    = sum_q[SUM_W-1];
	assign fmag    = fneg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dneg    = depth_q[31];
	assign dmag    = dneg ? 32'(-depth_q) : depth_q;
	assign fq_full = FQ_W'(fmag[SUM_W-1:15]) * FQ_W'(amp_scale_q);
	assign dq_full = 64'(dmag) * 64'(inv_dz_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN1) begin
			fq_s1   <= fq_full[FQ_W-1:8];
			dq_s1   <= dq_full[63:4];
			fneg_s1 <= fneg;
			dneg_s1 <= dneg;
		end
	end

	logic signed [67:0] total;
	logic [67:0]        rnd;
	logic [15:0]        idx_out;
	logic               sat_out;

	always_comb begin
		total = (dneg_s1 ? -68'(dq_s1) : 68'(dq_s1))
		      + (fneg_s1 ? -68'(fq_s1) : 68'(fq_s1));
		rnd   = 68'(total) + 68'h80000000;
		priority if (total <= 0) begin
			idx_out = '0;
			sat_out = 1'b0;
		end else if (rnd[67:32] > 36'd65535) begin
			idx_out = 16'hFFFF;
			sat_out = 1'b1;
		end else begin
			idx_out = rnd[47:32];
			sat_out = 1'b0;
		end
	end

	// output register
	logic        out_valid_q, sat_q;
	logic [15:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			index_q <= idx_out;
			sat_q   <= sat_out;
		end
	end

	assign out_valid   = out_valid_q;
	assign depth_index = index_q;
	assign saturated   = sat_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			primed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_REBUILD) begin
				primed_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		gen_load = 1'b0;
		gen_adv  = 1'b0;
		shift    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cnt_d = '0;
					if (first_column || !primed_q) begin
						gen_load = 1'b1;
						state_d  = ST_REBUILD;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_REBUILD: begin
				gen_adv = 1'b1;
				shift   = 1'b1;
				if (cnt_q == CW'(MAX_TERMS - 1)) begin
					cnt_d   = '0;
					state_d = ST_RUN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_RUN: begin
				shift = 1'b1;
				if (cnt_q == CW'(MAX_TERMS - 1)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN1;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_FIN1;
			ST_FIN1:   state_d = ST_FIN2;
			ST_FIN2: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// checks
	a_run_primed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> primed_q)
		else $error("term ring used before rebuild");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("result lost after load");

	a_sat_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sat_q |-> index_q == 16'hFFFF)
		else $error("saturated flag without full-scale index");

	a_no_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !act && !act_s1 && !act_s2)
		else $error("accumulate active in idle");
endmodule

/* hw/rtl/fis_cell.sv */
// fis_cell: one term slot of the rotating term ring.
// Depends on fis_pkg (term_t).
`timescale 1ns / 1ps
module fis_cell (
	input  logic           clk,
	input  logic           shift,
	input  fis_pkg::term_t d,
	output fis_pkg::term_t q
);
	import fis_pkg::*;

	term_t term_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			term_q <= d;
		end
	end

	assign q = term_q;
endmodule

/* hw/rtl/fis_term_gen.sv */
// fis_term_gen: drand48 start phases plus step and weight recurrences,
// one new term per advance. Depends on fis_pkg.
`timescale 1ns / 1ps
module fis_term_gen (
	input  logic           clk,
	input  logic           load,
	input  logic           adv,
	input  logic [31:0]    seed,
	input  logic [31:0]    base_step,
	input  logic [31:0]    freq_ratio,
	input  logic [23:0]    term_decay,
	output fis_pkg::term_t term
);
	import fis_pkg::*;

	logic [47:0] rng_q;
	logic [63:0] step_q;
	logic [24:0] weight_q;

	logic [58:0] p_lo;
	logic [47:0] p_hi;
	logic [47:0] rng_next;
	logic [63:0] sp_hi;
	logic [63:0] sp_lo;
	logic [63:0] step_next;
	logic [48:0] wp;

	always_comb begin
		// 48x35 LCG multiply split into two narrow partial products
		p_lo      = 59'(rng_q[23:0]) * 59'(LCG_MUL);
		p_hi      = 48'(rng_q[47:24]) * 48'(LCG_MUL[23:0]);
		rng_next  = p_lo[47:0] + {p_hi[23:0], 24'd0} + LCG_ADD;
		sp_hi     = 64'(step_q[63:32]) * 64'(freq_ratio);
		sp_lo     = 64'(step_q[31:0]) * 64'(freq_ratio);
		step_next = {sp_hi[55:0], 8'd0} + (sp_lo >> 24);
		wp        = 49'(weight_q) * 49'(term_decay);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rng_q    <= {seed, SEED_LOW};
			step_q   <= 64'(base_step);
			weight_q <= 25'h1000000;
		end else if (adv) begin
			rng_q    <= rng_next;
			step_q   <= step_next;
			weight_q <= wp[48:24];
		end
	end

	assign term = '{phase: rng_next[47:16], step: step_q[31:0], weight: weight_q};
endmodule

/* hw/rtl/fis_sine_rom.sv */
// fis_sine_rom: quarter-wave Q15 sine table with registered read.
// Depends on fis_pkg (sine_entry).
`timescale 1ns / 1ps
module fis_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                         clk,
	input  logic [$clog2(DEPTH+1)-1:0]   addr,
	output logic [14:0]                  data
);
	import fis_pkg::*;

	logic [14:0] rom [DEPTH+1];
	logic [14:0] data_q;

	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		localparam logic [63:0] X = (PI_Q30 * 64'(k)) / (64'd2 * 64'(DEPTH));
		assign rom[k] = sine_entry(X);
	end

	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

	assign data = data_q;
endmodule
